@@ rtl/core/indexed_ordered_list_store_unit_assert.svh @@
// Assertion macros shared by the list store RTL.
`ifndef INDEXED_ORDERED_LIST_STORE_UNIT_ASSERT_SVH
`define INDEXED_ORDERED_LIST_STORE_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Check with reset masking.
`define IOLS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that also runs across reset.
`define IOLS_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IOLS_ASSERT(label, clk, rst, prop, msg)
`define IOLS_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

@@ rtl/core/iols_pkg.sv @@
// Types and codes shared by the list store modules.
`default_nettype none
package iols_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_READ   = 2'd2,
    CMD_SWAP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_INSERT = 3'd1,
    ACT_DELETE = 3'd2,
    ACT_READ   = 3'd3,
    ACT_SWAP   = 3'd4
  } act_t;

  localparam int unsigned IDX_W   = 5;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned CNT_O_W = 5;
  localparam int unsigned VIEW_N  = 1 << IDX_W;

  // Classified command travelling from front to back.
  typedef struct packed {
    act_t                 act;
    logic [IDX_W-1:0]     index;
    logic [DATA_W-1:0]    value;
    logic [CNT_O_W-1:0]   item_count;
    status_t              status;
  } op_t;

  typedef struct packed {
    logic [DATA_W-1:0]    read_value;
    logic                 found;
    logic [CNT_O_W-1:0]   item_count;
    status_t              status;
  } result_t;

endpackage
`default_nettype wire

@@ rtl/core/indexed_ordered_list_store_unit.sv @@
// Top level of the indexed ordered list store.
// Each command is registered in the op queue and its result in the result queue.
// One command per cycle if no queue is full; inserts and deletes shift cells in parallel.
// Queues of two beats on each side of the back end absorb stalls on either side.
// Reset clears the count and both queues; entry cells are not cleared.
`default_nettype none
module indexed_ordered_list_store_unit #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         cmd,
  input  logic [4:0]         index,
  input  logic signed [31:0] value,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] read_value,
  output logic               found,
  output logic [4:0]         item_count,
  output logic [1:0]         status
);
  import iols_pkg::*;

  localparam int unsigned OP_W  = $bits(op_t);
  localparam int unsigned RES_W = $bits(result_t);

  op_t              fr_op;
  logic             fr_push;
  logic             q_full;
  logic             q_empty;
  logic [OP_W-1:0]  q_rdata;
  logic             bk_pop;
  op_t              bk_op;
  result_t          bk_res;
  logic             bk_push;
  logic             r_full;
  logic [RES_W-1:0] r_rdata;
  result_t          out_res;

  iols_front #(.CAPACITY(CAPACITY)) u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .cmd     (cmd_t'(cmd)),
    .index   (index),
    .value   (value),
    .op_push (fr_push),
    .op      (fr_op),
    .op_full (q_full)
  );

  iols_fifo #(.WIDTH(OP_W), .DEPTH(2)) u_op_q (
    .clk   (clk),
    .rst   (rst),
    .push  (fr_push),
    .wdata (fr_op),
    .full  (q_full),
    .pop   (bk_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign bk_op = op_t'(q_rdata);

  iols_back #(.CAPACITY(CAPACITY)) u_back (
    .clk      (clk),
    .rst      (rst),
    .op_valid (!q_empty),
    .op       (bk_op),
    .op_pop   (bk_pop),
    .res_push (bk_push),
    .res      (bk_res),
    .res_full (r_full)
  );

  iols_fifo #(.WIDTH(RES_W), .DEPTH(2)) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (bk_push),
    .wdata (bk_res),
    .full  (r_full),
    .pop   (pop),
    .rdata (r_rdata),
    .empty (empty)
  );

  assign out_res    = result_t'(r_rdata);
  assign read_value = out_res.read_value;
  assign found      = out_res.found;
  assign item_count = out_res.item_count;
  assign status     = out_res.status;

endmodule
`default_nettype wire

@@ rtl/core/iols_fifo.sv @@
// Small register queue used between the front and back and at the result side.
`default_nettype none
module iols_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  `include "indexed_ordered_list_store_unit_assert.svh"

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    fill;
  logic             do_push;
  logic             do_pop;

  assign full    = (fill == CW'(DEPTH));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + CW'(1);
        2'b01:   fill <= fill - CW'(1);
        default: fill <= fill;
      endcase
    end
  end

  `IOLS_ASSERT(a_fill_bound, clk, rst, fill <= CW'(DEPTH), "queue fill above depth")

endmodule
`default_nettype wire

@@ rtl/core/iols_front.sv @@
// Front: tracks the count, checks each command and emits a classified op.
`default_nettype none
module iols_front #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  iols_pkg::cmd_t      cmd,
  input  logic [4:0]          index,
  input  logic [31:0]         value,
  output logic                op_push,
  output iols_pkg::op_t       op,
  input  logic                op_full
);
  import iols_pkg::*;
  `include "indexed_ordered_list_store_unit_assert.svh"

  localparam int unsigned CNTW = $clog2(CAPACITY + 1);
  localparam int unsigned XW   = (CNTW > IDX_W) ? CNTW : IDX_W;

  logic [CNTW-1:0] count;
  logic [CNTW-1:0] count_next;
  logic [XW-1:0]   idx_x;
  logic [XW-1:0]   cnt_x;
  logic            in_fire;

  assign full    = op_full;
  assign in_fire = push && !op_full;
  assign op_push = in_fire;
  assign idx_x   = XW'(index);
  assign cnt_x   = XW'(count);

  always_comb begin
    op.act     = ACT_NONE;
    op.index   = index;
    op.value   = value;
    op.status  = ST_OK;
    count_next = count;
    unique case (cmd)
      CMD_INSERT: begin
        if (idx_x > cnt_x) begin
          op.status = ST_RANGE;
        end else if (count == CNTW'(CAPACITY)) begin
          op.status = ST_FULL;
        end else begin
          op.act     = ACT_INSERT;
          count_next = count + CNTW'(1);
        end
      end
      CMD_DELETE: begin
        if (idx_x >= cnt_x) begin
          op.status = ST_RANGE;
        end else begin
          op.act     = ACT_DELETE;
          count_next = count - CNTW'(1);
        end
      end
      CMD_READ: begin
        if (idx_x >= cnt_x) begin
          op.status = ST_RANGE;
        end else begin
          op.act = ACT_READ;
        end
      end
      CMD_SWAP: begin
        if (count >= CNTW'(2)) begin
          op.act = ACT_SWAP;
        end
      end
      default: begin
        op.act = ACT_NONE;
      end
    endcase
    op.item_count = CNT_O_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (in_fire) begin
      count <= count_next;
    end
  end

  `IOLS_ASSERT(a_count_bound, clk, rst, count <= CNTW'(CAPACITY), "count above capacity")
  `IOLS_ASSERT_NR(a_count_reset, clk, rst |=> count == '0, "count not cleared by reset")
  `IOLS_ASSERT(a_insert_grows, clk, rst,
    in_fire && op.act == ACT_INSERT |=> count == $past(count) + CNTW'(1),
    "insert did not grow count")

endmodule
`default_nettype wire

@@ rtl/core/iols_back.sv @@
// Back: entry cells with parallel shift, and result formation.
`default_nettype none
module iols_back #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                op_valid,
  input  iols_pkg::op_t       op,
  output logic                op_pop,
  output logic                res_push,
  output iols_pkg::result_t   res,
  input  logic                res_full
);
  import iols_pkg::*;
  `include "indexed_ordered_list_store_unit_assert.svh"

  logic [DATA_W-1:0] cells [CAPACITY];
  logic [DATA_W-1:0] view  [VIEW_N];
  logic [31:0]       idx32;
  logic              fire;

  assign fire     = op_valid && !res_full;
  assign op_pop   = fire;
  assign res_push = fire;
  assign idx32    = 32'(op.index);

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    localparam int unsigned PRV = (k > 0) ? k - 1 : k;
    localparam int unsigned NXT = (k < CAPACITY - 1) ? k + 1 : k;
    localparam int unsigned SWP = (k == 0) ? 1 : ((k == 1) ? 0 : k);
    localparam logic [31:0] K32 = 32'(k);

    always_ff @(posedge clk) begin
      if (fire) begin
        unique case (op.act)
          ACT_INSERT: begin
            if (K32 > idx32) begin
              cells[k] <= cells[PRV];
            end else if (K32 == idx32) begin
              cells[k] <= op.value;
            end
          end
          ACT_DELETE: begin
            if (K32 >= idx32) begin
              cells[k] <= cells[NXT];
            end
          end
          ACT_SWAP: begin
            if (k < 2) begin
              cells[k] <= cells[SWP];
            end
          end
          default: begin
            cells[k] <= cells[k];
          end
        endcase
      end
    end
  end

  // Only the first positions are addressable by a read.
  for (genvar j = 0; j < VIEW_N; j++) begin : g_view
    if (j < CAPACITY) begin : g_live
      assign view[j] = cells[j];
    end else begin : g_pad
      assign view[j] = '0;
    end
  end

  always_comb begin
    res.found      = (op.act == ACT_READ);
    res.read_value = res.found ? view[op.index] : '0;
    res.item_count = op.item_count;
    res.status     = op.status;
  end

  `IOLS_ASSERT(a_found_ok, clk, rst, res_push && res.found |-> res.status == ST_OK,
    "read hit with bad status")
  `IOLS_ASSERT(a_fail_no_act, clk, rst,
    op_valid && op.status != ST_OK |-> op.act == ACT_NONE,
    "failed command would change entries")

endmodule
`default_nettype wire

@@ bench/indexed_ordered_list_store_unit_tb.sv @@
// Self-checking bench for the indexed ordered list store: directed and random command beats.
module indexed_ordered_list_store_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import iols_pkg::*;

  localparam int unsigned LIST_DEPTH = 16;
  localparam int unsigned STALL_LIMIT = 5000;

  // Shadow copy of the list; one expected result per accepted command.
  class list_scoreboard;
    logic signed [31:0] cells [LIST_DEPTH];
    int unsigned count;
    result_t expected_q [$];
    int errors;

    function new();
      count = 0;
      errors = 0;
    endfunction

    function void note_command(logic [1:0] c, logic [4:0] idx, logic signed [31:0] v);
      result_t r;
      int unsigned k;
      r = '0;
      r.status = ST_OK;
      case (cmd_t'(c))
        CMD_INSERT: begin
          // range test wins over the full test
          if (idx > count) r.status = ST_RANGE;
          else if (count >= LIST_DEPTH) r.status = ST_FULL;
          else begin
            for (k = count; k > idx; k--) cells[k] = cells[k-1];
            cells[idx] = v;
            count++;
          end
        end
        CMD_DELETE: begin
          if (idx >= count) r.status = ST_RANGE;
          else begin
            for (k = idx; k + 1 < count; k++) cells[k] = cells[k+1];
            count--;
          end
        end
        CMD_READ: begin
          if (idx >= count) r.status = ST_RANGE;
          else begin
            r.read_value = cells[idx];
            r.found = 1'b1;
          end
        end
        default: begin
          if (count >= 2) begin
            r.read_value = cells[0];
            cells[0] = cells[1];
            cells[1] = r.read_value;
            r.read_value = '0;
          end
        end
      endcase
      r.item_count = 5'(count);
      expected_q.push_back(r);
    endfunction

    function void check_result(logic signed [31:0] rv, logic f, logic [4:0] ic, logic [1:0] st);
      result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: result beat with nothing expected (read_value %0d status %0d)",
                 $time, rv, st);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (rv !== e.read_value) begin
        $display("%0t: read_value expected %0d actual %0d", $time, $signed(e.read_value), rv);
        errors++;
      end
      if (f !== e.found) begin
        $display("%0t: found expected %0d actual %0d", $time, e.found, f);
        errors++;
      end
      if (ic !== e.item_count) begin
        $display("%0t: item_count expected %0d actual %0d", $time, e.item_count, ic);
        errors++;
      end
      if (st !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, st);
        errors++;
      end
    endfunction

    function int waiting();
      return expected_q.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  logic [1:0]         cmd = CMD_READ;
  logic [4:0]         index = '0;
  logic signed [31:0] value = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic signed [31:0] read_value;
  logic               found;
  logic [4:0]         item_count;
  logic [1:0]         status;

  list_scoreboard sb;
  int unsigned send_idle = 28;
  int unsigned recv_idle = 28;
  int unsigned stall_cycles = 0;

  indexed_ordered_list_store_unit #(.CAPACITY(LIST_DEPTH)) dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .cmd(cmd), .index(index), .value(value),
    .empty(empty), .pop(pop),
    .read_value(read_value), .found(found), .item_count(item_count), .status(status)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Stall watchdog: cycles with no beat on either side.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side: check on each accepted beat, then pick the next pop.
  initial begin
    forever begin
      @(posedge clk);
      if (pop && !empty && !rst) sb.check_result(read_value, found, item_count, status);
      pop <= !rst && ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send_cmd(input logic [1:0] c, input logic [4:0] i, input logic signed [31:0] v);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    cmd <= c;
    index <= i;
    value <= v;
    do @(posedge clk); while (full);
    sb.note_command(c, i, v);
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(15))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Mostly legal positions so the list fills and drains; some positions anywhere in the field.
  task automatic random_cmds(input int n, input int unsigned ins_weight);
    logic [1:0] c;
    logic [4:0] i;
    int unsigned r;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < ins_weight) begin
        c = CMD_INSERT;
        if ($urandom_range(9) == 0) i = 5'($urandom_range(31));
        else i = 5'($urandom_range(sb.count));
      end else begin
        r = $urandom_range(9);
        c = (r < 4) ? CMD_READ : (r < 8) ? CMD_DELETE : CMD_SWAP;
        if (sb.count > 0 && $urandom_range(7) != 0) i = 5'($urandom_range(sb.count - 1));
        else i = 5'($urandom_range(31));
      end
      send_cmd(c, i, pick_value());
    end
  endtask

  task automatic drain_results();
    push <= 1'b0;
    while (sb.waiting() != 0) @(posedge clk);
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // empty list: reads, deletes and inserts past the end are out of range, swap does nothing
    send_cmd(CMD_READ, 5'd0, '0);
    send_cmd(CMD_DELETE, 5'd0, '0);
    send_cmd(CMD_SWAP, 5'd0, '0);
    send_cmd(CMD_INSERT, 5'd1, 32'sd5);
    send_cmd(CMD_INSERT, 5'd31, -32'sd1);
    send_cmd(CMD_INSERT, 5'd0, 32'sh8000_0000);
    send_cmd(CMD_SWAP, 5'd31, '0);
    send_cmd(CMD_READ, 5'd1, '0);
    send_cmd(CMD_INSERT, 5'd1, 32'sh7fff_ffff);
    send_cmd(CMD_SWAP, 5'd0, '0);
    send_cmd(CMD_READ, 5'd0, '0);
    send_cmd(CMD_READ, 5'd1, '0);
    send_cmd(CMD_INSERT, 5'd2, -32'sd1);
    send_cmd(CMD_INSERT, 5'd1, '0);
    send_cmd(CMD_DELETE, 5'd3, '0);
    send_cmd(CMD_DELETE, 5'd0, '0);
    while (sb.count < LIST_DEPTH) send_cmd(CMD_INSERT, 5'($urandom_range(sb.count)), $urandom);
    // full list: index past the end still reports range first
    send_cmd(CMD_INSERT, 5'd17, 32'sd1);
    send_cmd(CMD_INSERT, 5'd16, 32'sd2);
    send_cmd(CMD_INSERT, 5'd0, 32'sd3);
    send_cmd(CMD_READ, 5'd15, '0);
    send_cmd(CMD_READ, 5'd16, '0);
    send_cmd(CMD_DELETE, 5'd16, '0);
    send_cmd(CMD_READ, 5'd31, '0);
    send_cmd(CMD_DELETE, 5'd15, '0);
    send_cmd(CMD_SWAP, 5'd0, '0);

    random_cmds(250, 60);
    drain_results();
    random_cmds(250, 15);
    // no idling on either side for this stretch
    send_idle = 0;
    recv_idle = 0;
    random_cmds(250, 45);
    send_idle = 28;
    recv_idle = 28;
    drain_results();
    random_cmds(250, 70);

    drain_results();
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
